[rtl/omc_pkg.sv]
// ----------------------------------------------------------------------------
// omc_pkg: shared definitions for the ohmmeter band classifier
// Widths, register indexes, E24 window tables, decade bounds and the types
// passed between the sequencer, the multiply-compare unit and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package omc_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SUM_W      = 22;
  localparam int unsigned RK_W       = 20;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned NUM_W      = RK_W + SUM_W;
  localparam int unsigned RES_W      = 24;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MULT_W     = 3;
  localparam int unsigned BOUND_W    = 20;
  localparam int unsigned OPND_W     = RES_W;
  localparam int unsigned WIN_W      = 5;
  localparam int unsigned WIN_COUNT  = 24;
  localparam int unsigned DEC_COUNT  = 5;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned BIT_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned ADC_FULL_SCALE_DEF = 4095;

  localparam logic [RK_W-1:0]  KNOWN_RES_RST = 20'd2200;
  localparam logic [CNT_W-1:0] SAMPLES_RST   = 10'd500;

  localparam logic [CFG_IDX_W-1:0] REG_KNOWN_RES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 2'd1;

  localparam logic [MULT_W-1:0] MULT_NONE   = 3'd0;
  localparam logic [MULT_W-1:0] MULT_BROWN  = 3'd1;
  localparam logic [MULT_W-1:0] MULT_RED    = 3'd2;
  localparam logic [MULT_W-1:0] MULT_ORANGE = 3'd3;
  localparam logic [MULT_W-1:0] MULT_YELLOW = 3'd4;

  localparam logic [WIN_W-1:0]  WIN_FIRST  = 5'd0;
  localparam logic [WIN_W-1:0]  WIN_LAST   = 5'(WIN_COUNT - 1);
  localparam logic [STEP_W-1:0] STEP_FIRST = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LAST  = 3'(DEC_COUNT - 1);
  localparam logic [BIT_W-1:0]  BIT_TOP    = 5'(RES_W - 1);

  // decade edges: above 400, then at or above 950, 1e4, 1e5, 1e6
  localparam logic [BOUND_W-1:0] DEC_BOUND [DEC_COUNT] = '{
    20'd400, 20'd950, 20'd10000, 20'd100000, 20'd1000000
  };

  // window bounds in hundredths of the decade base
  localparam logic [9:0] E24_LO [WIN_COUNT] = '{
    10'd95,  10'd105, 10'd115, 10'd125, 10'd145, 10'd155, 10'd175, 10'd190,
    10'd210, 10'd230, 10'd260, 10'd285, 10'd315, 10'd345, 10'd375, 10'd405,
    10'd455, 10'd485, 10'd532, 10'd589, 10'd646, 10'd713, 10'd779, 10'd865
  };
  localparam logic [9:0] E24_HI [WIN_COUNT] = '{
    10'd105, 10'd115, 10'd125, 10'd135, 10'd155, 10'd165, 10'd185, 10'd210,
    10'd230, 10'd250, 10'd280, 10'd315, 10'd345, 10'd375, 10'd405, 10'd455,
    10'd495, 10'd535, 10'd588, 10'd651, 10'd714, 10'd787, 10'd861, 10'd955
  };
  localparam logic [DIGIT_W-1:0] E24_D1 [WIN_COUNT] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
    4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3, 4'd3, 4'd4,
    4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd8, 4'd9
  };
  localparam logic [DIGIT_W-1:0] E24_D2 [WIN_COUNT] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd8, 4'd0,
    4'd2, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd9, 4'd3,
    4'd7, 4'd1, 4'd6, 4'd2, 4'd8, 4'd5, 4'd2, 4'd1
  };

  typedef struct packed {
    logic [RES_W-1:0]   resistance;
    logic               in_range;
    logic               band_found;
    logic [DIGIT_W-1:0] first;
    logic [DIGIT_W-1:0] second;
    logic [MULT_W-1:0]  mult;
  } meas_res_t;

  typedef struct packed {
    logic ge;
    logic gt;
  } cmp_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_QUO_MUL,
    SQ_QUO_CMP,
    SQ_DEC_MUL,
    SQ_DEC_CMP,
    SQ_WIN_MUL,
    SQ_WIN_CMP,
    SQ_DONE
  } seq_state_t;

  typedef enum logic [2:0] {
    T_ACC,
    T_MUL,
    T_SUB,
    T_GO,
    T_WAIT
  } top_state_t;

  // window bound scaled to the decade, in ohms / 100 of the base
  function automatic logic [BOUND_W-1:0] window_bound(
    input logic [WIN_W-1:0]  win,
    input logic              hi_sel,
    input logic [MULT_W-1:0] mult
  );
    logic [BOUND_W-1:0] base;
    logic [BOUND_W-1:0] bound;
    base = hi_sel ? BOUND_W'(E24_HI[win]) : BOUND_W'(E24_LO[win]);
    unique case (mult)
      MULT_BROWN:  bound = base;
      MULT_RED:    bound = base * 20'd10;
      MULT_ORANGE: bound = base * 20'd100;
      MULT_YELLOW: bound = base * 20'd1000;
      default:     bound = '0;
    endcase
    return bound;
  endfunction

endpackage

`default_nettype wire

[rtl/ohmmeter_e24_band_classifier_core.sv]
// ----------------------------------------------------------------------------
// ohmmeter_e24_band_classifier_core: ratiometric ohmmeter with E24 bands
// Sums divider samples, then finds R = Rk*S/(FS*N - S), its decade and its
// E24 band digits with one shared multiply-compare unit.
// Non-final samples: one per cycle. After the final sample none is taken
// until the result is loaded into the output register. Each comparison in
// the multiply-compare unit registers a product, then compares (24 quotient
// bits, 5 decade edges, up to 48 window edges); a zero denominator skips them.
// Reset: synchronous; clears sum, count and valid, loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module ohmmeter_e24_band_classifier_core
  import omc_pkg::*;
#(
  parameter int unsigned ADC_FULL_SCALE = ADC_FULL_SCALE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  sample_valid,
  output logic                       sample_ready,
  input  wire logic [SAMPLE_W-1:0]   sample,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output logic [RES_W-1:0]           resistance_ohms,
  output logic                       in_range,
  output logic                       band_found,
  output logic [DIGIT_W-1:0]         first_digit,
  output logic [DIGIT_W-1:0]         second_digit,
  output logic [MULT_W-1:0]          multiplier_digit
);

  localparam int unsigned FS_W   = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned DEN_W  = FS_W + CNT_W;
  localparam int unsigned DCMP_W = (DEN_W > SUM_W) ? DEN_W : SUM_W;

  top_state_t state, state_next;

  logic [RK_W-1:0]  known_res;
  logic [CNT_W-1:0] samples;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] idx;
  logic [SUM_W-1:0] s_hold;
  logic [CNT_W-1:0] n_hold;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] full;
  logic [DEN_W-1:0] den;
  logic             den_zero;
  meas_res_t        out_res;

  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] n_eff;
  logic             last;
  logic             in_xfer;
  logic             start;
  logic             ack;
  logic             done;
  meas_res_t        seq_res;

  omc_seq #(
    .DEN_W (DEN_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .ack      (ack),
    .num      (num),
    .den      (den),
    .den_zero (den_zero),
    .done     (done),
    .res      (seq_res)
  );

  assign cfg_ready = 1'b1;
  assign sum_next  = sum + SUM_W'(sample);
  assign n_eff     = (samples == '0) ? CNT_W'(1) : samples;
  assign last      = !(({1'b0, idx} + 1'b1) < {1'b0, n_eff});
  assign in_xfer   = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    start        = 1'b0;
    ack          = 1'b0;
    unique case (state)
      T_ACC: begin
        sample_ready = 1'b1;
        if (sample_valid && last) begin
          state_next = T_MUL;
        end
      end
      T_MUL: state_next = T_SUB;
      T_SUB: state_next = T_GO;
      T_GO: begin
        start      = 1'b1;
        state_next = T_WAIT;
      end
      T_WAIT: begin
        if (done && (!result_valid || result_ready)) begin
          ack        = 1'b1;
          state_next = T_ACC;
        end
      end
      default: state_next = T_ACC;
    endcase
  end

  // configuration and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      known_res <= KNOWN_RES_RST;
      samples   <= SAMPLES_RST;
      sum       <= '0;
      idx       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KNOWN_RES) begin
          known_res <= cfg_data[RK_W-1:0];
        end else if (cfg_index == REG_SAMPLES) begin
          samples <= cfg_data[CNT_W-1:0];
        end
      end
      if (in_xfer) begin
        if (last) begin
          sum <= '0;
          idx <= '0;
        end else begin
          sum <= sum_next;
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && last) begin
      s_hold <= sum_next;
      n_hold <= n_eff;
    end
    if (state == T_MUL) begin
      num  <= NUM_W'(known_res) * NUM_W'(s_hold);
      full <= DEN_W'(FS_W'(ADC_FULL_SCALE)) * DEN_W'(n_hold);
    end
    if (state == T_SUB) begin
      den_zero <= DCMP_W'(s_hold) >= DCMP_W'(full);
      den      <= full - DEN_W'(s_hold);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ack) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      out_res <= seq_res;
    end
  end

  assign resistance_ohms  = out_res.resistance;
  assign in_range         = out_res.in_range;
  assign band_found       = out_res.band_found;
  assign first_digit      = out_res.first;
  assign second_digit     = out_res.second;
  assign multiplier_digit = out_res.mult;

endmodule

`default_nettype wire

[rtl/omc_mul_cmp.sv]
// ----------------------------------------------------------------------------
// omc_mul_cmp: shared multiply-compare unit
// Registers den * operand, then compares the numerator against the product.
// ----------------------------------------------------------------------------
`default_nettype none

module omc_mul_cmp
  import omc_pkg::*;
#(
  parameter int unsigned DEN_W = 22
) (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic [DEN_W-1:0]  den,
  input  wire logic [OPND_W-1:0] opnd,
  input  wire logic [NUM_W-1:0]  num,
  output cmp_t                   cmp
);

  localparam int unsigned PROD_W = DEN_W + OPND_W;
  localparam int unsigned CMP_W  = (PROD_W > NUM_W) ? PROD_W : NUM_W;

  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'(den) * PROD_W'(opnd);
    end
  end

  always_comb begin
    cmp.ge = CMP_W'(num) >= CMP_W'(prod);
    cmp.gt = CMP_W'(num) >  CMP_W'(prod);
  end

endmodule

`default_nettype wire

[rtl/omc_seq.sv]
// ----------------------------------------------------------------------------
// omc_seq: measurement sequencer
// Drives the multiply-compare unit through a bit-by-bit quotient search,
// the decade bounds and the E24 windows, and holds the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module omc_seq
  import omc_pkg::*;
#(
  parameter int unsigned DEN_W = 22
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             ack,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic             den_zero,
  output logic                  done,
  output meas_res_t             res
);

  seq_state_t state, state_next;

  logic [BIT_W-1:0]   bit_idx;
  logic [RES_W-1:0]   quo;
  logic [STEP_W-1:0]  step;
  logic [3:0]         dec_flags;
  logic [WIN_W-1:0]   win;
  logic               hi_sel;
  logic [MULT_W-1:0]  mult;
  logic               in_range;
  logic               band_found;
  logic [DIGIT_W-1:0] first;
  logic [DIGIT_W-1:0] second;

  logic [OPND_W-1:0]  trial;
  logic [OPND_W-1:0]  opnd;
  logic               load;
  logic               flag;
  logic [4:0]         dec_all;
  logic [MULT_W-1:0]  dec_mult;
  cmp_t               cmp;

  omc_mul_cmp #(
    .DEN_W (DEN_W)
  ) u_mul_cmp (
    .clk  (clk),
    .load (load),
    .den  (den),
    .opnd (opnd),
    .num  (num),
    .cmp  (cmp)
  );

  assign trial = quo | (OPND_W'(1) << bit_idx);

  always_comb begin
    unique case (state)
      SQ_QUO_MUL, SQ_QUO_CMP: opnd = trial;
      SQ_DEC_MUL, SQ_DEC_CMP: opnd = OPND_W'(DEC_BOUND[step]);
      SQ_WIN_MUL, SQ_WIN_CMP: opnd = OPND_W'(window_bound(win, hi_sel, mult));
      default:                opnd = '0;
    endcase
  end

  // lowest edge is strict, the others inclusive
  assign flag    = (step == STEP_FIRST) ? cmp.gt : cmp.ge;
  assign dec_all = {flag, dec_flags};

  always_comb begin
    priority if (dec_all[0] && !dec_all[1]) begin
      dec_mult = MULT_BROWN;
    end else if (dec_all[1] && !dec_all[2]) begin
      dec_mult = MULT_RED;
    end else if (dec_all[2] && !dec_all[3]) begin
      dec_mult = MULT_ORANGE;
    end else if (dec_all[3] && !dec_all[4]) begin
      dec_mult = MULT_YELLOW;
    end else begin
      dec_mult = MULT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    done       = 1'b0;
    unique case (state)
      SQ_IDLE: begin
        if (start) begin
          state_next = den_zero ? SQ_DONE : SQ_QUO_MUL;
        end
      end
      SQ_QUO_MUL: begin
        load       = 1'b1;
        state_next = SQ_QUO_CMP;
      end
      SQ_QUO_CMP: begin
        state_next = (bit_idx == '0) ? SQ_DEC_MUL : SQ_QUO_MUL;
      end
      SQ_DEC_MUL: begin
        load       = 1'b1;
        state_next = SQ_DEC_CMP;
      end
      SQ_DEC_CMP: begin
        if (step == STEP_LAST) begin
          state_next = (dec_mult == MULT_NONE) ? SQ_DONE : SQ_WIN_MUL;
        end else begin
          state_next = SQ_DEC_MUL;
        end
      end
      SQ_WIN_MUL: begin
        load       = 1'b1;
        state_next = SQ_WIN_CMP;
      end
      SQ_WIN_CMP: begin
        if (!hi_sel && cmp.gt) begin
          state_next = SQ_WIN_MUL;
        end else if (hi_sel && !cmp.ge) begin
          state_next = SQ_DONE;
        end else begin
          state_next = (win == WIN_LAST) ? SQ_DONE : SQ_WIN_MUL;
        end
      end
      SQ_DONE: begin
        done = 1'b1;
        if (ack) begin
          state_next = SQ_IDLE;
        end
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      SQ_IDLE: begin
        if (start) begin
          quo        <= den_zero ? '1 : '0;
          bit_idx    <= BIT_TOP;
          step       <= STEP_FIRST;
          dec_flags  <= '0;
          win        <= WIN_FIRST;
          hi_sel     <= 1'b0;
          mult       <= MULT_NONE;
          in_range   <= 1'b0;
          band_found <= 1'b0;
          first      <= '0;
          second     <= '0;
        end
      end
      SQ_QUO_CMP: begin
        if (cmp.ge) begin
          quo <= trial;
        end
        bit_idx <= bit_idx - 1'b1;
      end
      SQ_DEC_CMP: begin
        dec_flags <= {flag, dec_flags[3:1]};
        step      <= step + 1'b1;
        if (step == STEP_LAST) begin
          mult     <= dec_mult;
          in_range <= (dec_mult != MULT_NONE);
        end
      end
      SQ_WIN_CMP: begin
        if (!hi_sel && cmp.gt) begin
          hi_sel <= 1'b1;
        end else if (hi_sel && !cmp.ge) begin
          band_found <= 1'b1;
          first      <= E24_D1[win];
          second     <= E24_D2[win];
        end else begin
          hi_sel <= 1'b0;
          win    <= win + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.resistance = quo;
    res.in_range   = in_range;
    res.band_found = band_found;
    res.first      = first;
    res.second     = second;
    res.mult       = mult;
  end

endmodule

`default_nettype wire

[rtl/omc_checker.sv]
// ----------------------------------------------------------------------------
// omc_checker: port-level checks for the band classifier
// Watches the result channel for reset, hold and field consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module omc_checker
  import omc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  result_valid,
  input wire logic                  result_ready,
  input wire logic [RES_W-1:0]      resistance_ohms,
  input wire logic                  in_range,
  input wire logic                  band_found,
  input wire logic [DIGIT_W-1:0]    first_digit,
  input wire logic [DIGIT_W-1:0]    second_digit,
  input wire logic [MULT_W-1:0]     multiplier_digit
);

  // result held until transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(resistance_ohms)
      && $stable(multiplier_digit) && $stable(first_digit) && $stable(second_digit))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (in_range == (multiplier_digit != MULT_NONE))
      && (multiplier_digit == MULT_NONE || multiplier_digit == MULT_BROWN
        || multiplier_digit == MULT_RED || multiplier_digit == MULT_ORANGE
        || multiplier_digit == MULT_YELLOW))
    else $error("multiplier does not match range flag");

  a_band: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (band_found ? (in_range && first_digit != '0)
      : (first_digit == '0 && second_digit == '0)))
    else $error("band digits inconsistent");

endmodule

bind ohmmeter_e24_band_classifier_core omc_checker u_omc_checker (.*);

`default_nettype wire

[verif/ohmmeter_e24_band_classifier_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ohmmeter_e24_band_classifier_checker: reading predictor and scoreboard
// Watches the register, sample and result channels of the band classifier,
// keeps its own copy of the registers and the running sum, computes the
// expected reading for every completed measurement and compares each result
// transfer with the oldest expected reading.
// ----------------------------------------------------------------------------
module ohmmeter_e24_band_classifier_checker
  import omc_pkg::*;
#(
  parameter int unsigned FULL_SCALE = ADC_FULL_SCALE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  sample_valid,
  input  wire logic                  sample_ready,
  input  wire logic [SAMPLE_W-1:0]   sample,
  input  wire logic                  result_valid,
  input  wire logic                  result_ready,
  input  wire logic [RES_W-1:0]      resistance_ohms,
  input  wire logic                  in_range,
  input  wire logic                  band_found,
  input  wire logic [DIGIT_W-1:0]    first_digit,
  input  wire logic [DIGIT_W-1:0]    second_digit,
  input  wire logic [MULT_W-1:0]     multiplier_digit,
  output int                         mismatches,
  output int                         outstanding
);

  localparam int REPORT_LIMIT = 10;
  localparam int BANDS        = 24;

  localparam logic [RK_W-1:0]  OHMS_DEFAULT  = 20'd2200;
  localparam logic [CNT_W-1:0] COUNT_DEFAULT = 10'd500;

  localparam logic [63:0] BROWN_FLOOR  = 64'd400;
  localparam logic [63:0] RED_FLOOR    = 64'd950;
  localparam logic [63:0] ORANGE_FLOOR = 64'd10000;
  localparam logic [63:0] YELLOW_FLOOR = 64'd100000;
  localparam logic [63:0] DECADE_TOP   = 64'd1000000;
  localparam logic [63:0] OHMS_CEILING = 64'd16777215;

  // window edges in hundredths of the decade base, searched in this order
  localparam int unsigned BAND_LO [BANDS] = '{
    95, 105, 115, 125, 145, 155, 175, 190, 210, 230, 260, 285,
    315, 345, 375, 405, 455, 485, 532, 589, 646, 713, 779, 865
  };
  localparam int unsigned BAND_HI [BANDS] = '{
    105, 115, 125, 135, 155, 165, 185, 210, 230, 250, 280, 315,
    345, 375, 405, 455, 495, 535, 588, 651, 714, 787, 861, 955
  };
  localparam int unsigned BAND_TENS [BANDS] = '{
    1, 1, 1, 1, 1, 1, 1, 2, 2, 2, 2, 3, 3, 3, 3, 4, 4, 5, 5, 6, 6, 7, 8, 9
  };
  localparam int unsigned BAND_UNITS [BANDS] = '{
    0, 1, 2, 3, 5, 6, 8, 0, 2, 4, 7, 0, 3, 6, 9, 3, 7, 1, 6, 2, 8, 5, 2, 1
  };

  logic [RK_W-1:0]  ohms_ref;
  logic [CNT_W-1:0] count_reg;
  logic [SUM_W-1:0] code_sum;
  logic [CNT_W-1:0] code_count;
  meas_res_t        pending_readings [$];
  int               err_total = 0;

  function automatic meas_res_t classify_reading(
    input logic [RK_W-1:0]  ohms,
    input logic [SUM_W-1:0] total,
    input logic [CNT_W-1:0] count
  );
    meas_res_t         r;
    logic [63:0]       full;
    logic [63:0]       den;
    logic [63:0]       num;
    logic [63:0]       quo;
    logic [63:0]       scale;
    logic [63:0]       lo;
    logic [63:0]       hi;
    logic [MULT_W-1:0] mult;
    r = '0;
    r.resistance = '1;
    full = 64'(FULL_SCALE) * 64'(count);
    den = (64'(total) < full) ? full - 64'(total) : 64'd0;
    num = 64'(ohms) * 64'(total);
    if (den != 64'd0) begin
      quo = num / den;
      r.resistance = (quo > OHMS_CEILING) ? '1 : quo[RES_W-1:0];
      mult = MULT_NONE;
      scale = 64'd0;
      if (num > BROWN_FLOOR * den && num < RED_FLOOR * den) begin
        mult = MULT_BROWN;
        scale = 64'd1;
      end else if (num >= RED_FLOOR * den && num < ORANGE_FLOOR * den) begin
        mult = MULT_RED;
        scale = 64'd10;
      end else if (num >= ORANGE_FLOOR * den && num < YELLOW_FLOOR * den) begin
        mult = MULT_ORANGE;
        scale = 64'd100;
      end else if (num >= YELLOW_FLOOR * den && num < DECADE_TOP * den) begin
        mult = MULT_YELLOW;
        scale = 64'd1000;
      end
      if (mult != MULT_NONE) begin
        r.in_range = 1'b1;
        r.mult = mult;
        for (int k = 0; k < BANDS; k++) begin
          lo = 64'(BAND_LO[k]) * scale * den;
          hi = 64'(BAND_HI[k]) * scale * den;
          if (!r.band_found && lo < num && num < hi) begin
            r.band_found = 1'b1;
            r.first = DIGIT_W'(BAND_TENS[k]);
            r.second = DIGIT_W'(BAND_UNITS[k]);
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    meas_res_t        seen;
    meas_res_t        want;
    logic [CNT_W-1:0] n_eff;
    if (rst) begin
      ohms_ref = OHMS_DEFAULT;
      count_reg = COUNT_DEFAULT;
      code_sum = '0;
      code_count = '0;
      pending_readings.delete();
    end else begin
      if (result_valid && result_ready) begin
        seen = {resistance_ohms, in_range, band_found, first_digit, second_digit,
                multiplier_digit};
        if (pending_readings.size() == 0) begin
          err_total++;
          if (err_total <= REPORT_LIMIT) begin
            $display("%0t: result transfer with no reading due: %0d ohms mult %0d",
                     $realtime, seen.resistance, seen.mult);
          end
        end else begin
          want = pending_readings.pop_front();
          if (seen !== want) begin
            err_total++;
            if (err_total <= REPORT_LIMIT) begin
              $display("%0t: reading mismatch, expected %0d ohms range %0b band %0b %0d/%0d mult %0d",
                       $realtime, want.resistance, want.in_range, want.band_found,
                       want.first, want.second, want.mult);
              $display("%0t:                   actual %0d ohms range %0b band %0b %0d/%0d mult %0d",
                       $realtime, seen.resistance, seen.in_range, seen.band_found,
                       seen.first, seen.second, seen.mult);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KNOWN_RES) begin
          ohms_ref = cfg_data[RK_W-1:0];
        end else if (cfg_index == REG_SAMPLES) begin
          count_reg = cfg_data[CNT_W-1:0];
        end
      end
      if (sample_valid && sample_ready) begin
        n_eff = (count_reg == '0) ? CNT_W'(1) : count_reg;
        code_sum = code_sum + SUM_W'(sample);
        if (int'(code_count) + 1 < int'(n_eff)) begin
          code_count = code_count + 1'b1;
        end else begin
          pending_readings.push_back(classify_reading(ohms_ref, code_sum, n_eff));
          code_sum = '0;
          code_count = '0;
        end
      end
    end
    mismatches <= err_total;
    outstanding <= pending_readings.size();
  end

endmodule

[verif/ohmmeter_e24_band_classifier_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ohmmeter_e24_band_classifier_core_test: testbench top for the band classifier
// Drives register writes and ADC samples with random gaps and stalls, runs
// directed decade and window corners, then random measurements of mostly
// small sample counts, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module ohmmeter_e24_band_classifier_core_test;
  import omc_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 20000;
  localparam int ITEM_TARGET   = 1550;
  localparam int RESULT_TARGET = 60;
  localparam int CORNERS       = 10;
  localparam int CODE_MAX      = 4095;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  logic [SAMPLE_W-1:0]   sample       = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  logic [RES_W-1:0]      resistance_ohms;
  logic                  in_range;
  logic                  band_found;
  logic [DIGIT_W-1:0]    first_digit;
  logic [DIGIT_W-1:0]    second_digit;
  logic [MULT_W-1:0]     multiplier_digit;
  int                    mismatches;
  int                    outstanding;

  bit quiet_feed   = 1'b0;
  bit quiet_drain  = 1'b0;
  bit hold_request = 1'b0;
  int samples_sent = 0;
  int readings_got = 0;

  ohmmeter_e24_band_classifier_core u_top (.*);

  ohmmeter_e24_band_classifier_checker u_check (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      readings_got <= readings_got + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 16);
    end
    return $urandom_range(40, 150);
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] code);
    int gap;
    gap = quiet_feed ? 0 : pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= code;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    samples_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // wait for every reading to come back and the core to go quiet
  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [RK_W-1:0] ohms, input logic [CFG_DATA_W-1:0] count_word);
    settle();
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
    end
    write_reg(REG_KNOWN_RES, CFG_DATA_W'(ohms));
    write_reg(REG_SAMPLES, count_word);
    cfg_valid <= 1'b0;
  endtask

  // divider codes around one level, with an occasional wide spread
  task automatic send_measurement(input int count);
    int level;
    int spread;
    int code;
    int r;
    r = $urandom_range(0, 9);
    level = (r == 0) ? 0 : (r == 1) ? CODE_MAX : $urandom_range(0, CODE_MAX);
    spread = ($urandom_range(0, 3) == 0) ? 2048 : $urandom_range(0, 8);
    for (int k = 0; k < count; k++) begin
      code = level + $urandom_range(0, 2 * spread) - spread;
      if (code < 0) code = 0;
      if (code > CODE_MAX) code = CODE_MAX;
      send_sample(SAMPLE_W'(code));
    end
  endtask

  // two codes summing to full scale: with two samples per reading R equals Rk
  task automatic send_balanced_pair(input bit extremes);
    int code;
    code = extremes ? 0 : $urandom_range(0, CODE_MAX);
    send_sample(SAMPLE_W'(code));
    send_sample(SAMPLE_W'(CODE_MAX - code));
  endtask

  function automatic logic [RK_W-1:0] pick_ohms();
    logic [RK_W-1:0] ohms;
    ohms = RK_W'($urandom_range(1, 20'hFFFFF) >> $urandom_range(0, 19));
    if ($urandom_range(0, 19) == 0) ohms = '1;
    if (ohms == '0) ohms = RK_W'(1);
    return ohms;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] count_word(input logic [CNT_W-1:0] count);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
    if ($urandom_range(0, 1) == 0) word = '0;
    word[CNT_W-1:0] = count;
    return word;
  endfunction

  initial begin : drain
    int gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gap_left > 0) begin
        result_ready <= 1'b0;
        gap_left--;
      end else begin
        result_ready <= 1'b1;
        if (!quiet_drain && $urandom_range(0, 99) < 20) gap_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [RK_W-1:0]  corner_ohms [CORNERS];
    logic [CNT_W-1:0] count;
    int               n_eff;
    int               r;
    int               phase;
    corner_ohms = '{20'd400, 20'd401, 20'd950, 20'd949, 20'd10000, 20'd105000,
                    20'd48900, 20'd999999, 20'd1000000, 20'hFFFFF};
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // register defaults, then a partial measurement left behind
    send_measurement(500);
    repeat (7) send_sample(SAMPLE_W'($urandom_range(0, CODE_MAX)));
    settle();
    write_reg(REG_SAMPLES, 20'hFFC02);
    write_reg(REG_KNOWN_RES, corner_ohms[0]);
    cfg_valid <= 1'b0;
    send_sample('1);

    // decade and window edges
    for (int k = 0; k < CORNERS; k++) begin
      configure(corner_ohms[k], CFG_DATA_W'(2));
      send_balanced_pair(k == 0);
    end
    configure('1, CFG_DATA_W'(1));
    send_sample('1);
    send_sample('0);
    send_sample(SAMPLE_W'(CODE_MAX - 1));
    configure(20'd2200, CFG_DATA_W'(0));
    send_sample('1);
    send_sample(SAMPLE_W'(2048));

    // largest sample count, once
    configure(pick_ohms(), count_word('1));
    send_measurement(1023);

    phase = 0;
    while (samples_sent < ITEM_TARGET || readings_got < RESULT_TARGET) begin
      if (phase == 0 || phase == 15) begin
        configure(pick_ohms(), count_word(CNT_W'(1)));
        quiet_feed = 1'b1;
        hold_request = 1'b1;
        repeat (40) send_sample(SAMPLE_W'($urandom_range(0, CODE_MAX)));
        quiet_feed = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          count = '0;
        end else if (r < 25) begin
          count = CNT_W'(1);
        end else if (r < 80) begin
          count = CNT_W'($urandom_range(2, 8));
        end else if (r < 95) begin
          count = CNT_W'($urandom_range(9, 40));
        end else begin
          count = CNT_W'($urandom_range(41, 150));
        end
        n_eff = (count == '0) ? 1 : int'(count);
        configure(pick_ohms(), count_word(count));
        quiet_feed = ($urandom_range(0, 4) == 0);
        quiet_drain = ($urandom_range(0, 4) == 0);
        repeat ($urandom_range(1, 5)) send_measurement(n_eff);
        if (n_eff > 1 && $urandom_range(0, 2) == 0) begin
          send_measurement($urandom_range(1, n_eff - 1));
        end
        quiet_feed = 1'b0;
        quiet_drain = 1'b0;
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
